### sv/mfd_pkg.sv
// types, constants and crc function shared by the frame deframer
package mfd_pkg;

    localparam int unsigned ID_BYTES = 17;
    localparam logic [15:0] HDR_BYTES = 16'(ID_BYTES + 5);
    localparam logic [15:0] IDX_LEN_HI = 16'd1;
    localparam logic [15:0] IDX_TYPE = 16'(ID_BYTES + 2);
    localparam logic [15:0] IDX_PACKET = 16'(ID_BYTES + 3);
    localparam logic [15:0] IDX_SEQ = 16'(ID_BYTES + 4);

    localparam logic [7:0] SYNC_FIRST = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam logic [7:0] TRAILER_BYTE = 8'h96;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int unsigned OUT_DATA_W = 48;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRCLO,
        PH_CRCHI,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD,
        KIND_GOOD,
        KIND_BAD_TRAILER,
        KIND_BAD_CRC,
        KIND_TRUNCATED
    } kind_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/monitor_frame_deframer.sv
// deframer for sync, length and crc16 framed byte streams
// output: a result is registered and appears on the master side in the cycle after its word is accepted
// one word per cycle unless the master stalls; output register frees in the cycle taken
// the byte-wide crc update and the header capture sit between the state and output registers
// reset: synchronous active-low aresetn returns to hunting for the first sync byte
// and drops the output valid; no clearing pass
module monitor_frame_deframer
    import mfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // rx_byte
    input  logic                  s_axis_tlast,   // buffer_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // data_byte, frame_kind, packet_kind,
                                                  // sequence_number, payload_length
    output logic [2:0]            m_axis_tuser,   // kind
    output logic                  m_axis_tlast    // end_of_frame
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  packet_reg, packet_next;
    logic [7:0]  seq_reg, seq_next;
    logic        crc_ok_reg, crc_ok_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic        out_free;
    logic        s_acc;
    logic        emit;
    kind_t       emit_kind;
    logic [7:0]  emit_byte;
    logic [15:0] crc_upd;
    logic [15:0] count_inc;
    logic [7:0]  b;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = out_free;
    assign s_acc = s_axis_tvalid && out_free;
    assign b = s_axis_tdata;
    assign crc_upd = crc16_byte(crc_reg, b);
    assign count_inc = count_reg + 16'd1;

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        type_next   = type_reg;
        packet_next = packet_reg;
        seq_next    = seq_reg;
        crc_ok_next = crc_ok_reg;
        emit        = 1'b0;
        emit_kind   = KIND_PAYLOAD;
        emit_byte   = 8'h00;
        if (s_acc) begin
            unique case (phase_reg)
                PH_HEADER, PH_PAYLOAD, PH_CRCLO, PH_CRCHI, PH_TRAIL: begin
                    if (s_axis_tlast && phase_reg != PH_TRAIL) begin
                        phase_next = PH_HUNT1;
                        emit       = 1'b1;
                        emit_kind  = KIND_TRUNCATED;
                    end else begin
                        unique case (phase_reg)
                            PH_HEADER: begin
                                crc_next = crc_upd;
                                if (count_reg == 16'd0) begin
                                    len_next = {8'h00, b};
                                end else if (count_reg == IDX_LEN_HI) begin
                                    len_next = {b, len_reg[7:0]};
                                end else if (count_reg == IDX_TYPE) begin
                                    type_next = b;
                                end else if (count_reg == IDX_PACKET) begin
                                    packet_next = b;
                                end else if (count_reg == IDX_SEQ) begin
                                    seq_next = b;
                                end
                                count_next = count_inc;
                                if (count_inc >= HDR_BYTES) begin
                                    count_next = 16'd0;
                                    phase_next = (len_next == 16'd0) ? PH_CRCLO : PH_PAYLOAD;
                                end
                            end
                            PH_PAYLOAD: begin
                                crc_next   = crc_upd;
                                count_next = count_inc;
                                if (count_inc >= len_reg) begin
                                    phase_next = PH_CRCLO;
                                end
                                emit      = 1'b1;
                                emit_kind = KIND_PAYLOAD;
                                emit_byte = b;
                            end
                            PH_CRCLO: begin
                                crc_lo_next = b;
                                phase_next  = PH_CRCHI;
                            end
                            PH_CRCHI: begin
                                crc_ok_next = ({b, crc_lo_reg} == crc_reg);
                                phase_next  = PH_TRAIL;
                            end
                            default: begin
                                emit       = 1'b1;
                                phase_next = PH_HUNT1;
                                if (b != TRAILER_BYTE) begin
                                    emit_kind = KIND_BAD_TRAILER;
                                end else if (!crc_ok_reg) begin
                                    emit_kind = KIND_BAD_CRC;
                                end else begin
                                    emit_kind = KIND_GOOD;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    if (s_axis_tlast) begin
                        phase_next = PH_HUNT1;
                    end else if (phase_reg == PH_HUNT2 && b == SYNC_SECOND) begin
                        phase_next  = PH_HEADER;
                        count_next  = 16'd0;
                        len_next    = 16'd0;
                        crc_next    = CRC_INIT;
                        crc_lo_next = 8'h00;
                        type_next   = 8'h00;
                        packet_next = 8'h00;
                        seq_next    = 8'h00;
                        crc_ok_next = 1'b0;
                    end else if (b == SYNC_FIRST) begin
                        phase_next = PH_HUNT2;
                    end else begin
                        phase_next = PH_HUNT1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (out_free) begin
            out_valid_next = s_acc && emit;
            out_kind_next  = emit_kind;
            out_data_next  = {len_reg, seq_reg, packet_reg, type_reg, emit_byte};
            out_last_next  = (emit_kind != KIND_PAYLOAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT1;
            count_reg     <= 16'd0;
            len_reg       <= 16'd0;
            crc_reg       <= CRC_INIT;
            crc_lo_reg    <= 8'h00;
            type_reg      <= 8'h00;
            packet_reg    <= 8'h00;
            seq_reg       <= 8'h00;
            crc_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            type_reg      <= type_next;
            packet_reg    <= packet_next;
            seq_reg       <= seq_next;
            crc_ok_reg    <= crc_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // a payload word never closes a frame, a verdict always does
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_PAYLOAD)))
        else $error("end_of_frame does not match kind");

    // data byte is zero on verdict words
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |-> (m_axis_tdata[7:0] == 8'h00))
        else $error("nonzero data byte on verdict");

    // any verdict sends the block back to hunting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && emit && emit_kind != KIND_PAYLOAD) |=> (phase_reg == PH_HUNT1))
        else $error("no return to hunt after verdict");

    // words accepted while hunting never produce a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (phase_reg == PH_HUNT1 || phase_reg == PH_HUNT2)) |=> !m_axis_tvalid)
        else $error("result produced while hunting");

endmodule
